FILE: hdl/hcic_pkg.sv
// Package for the Hilbert curve index codec: item types, control group and register map.
// Used by hcic_cfg, hcic_stage and hilbert_curve_index_codec_unit. No dependencies.
package hcic_pkg;

    localparam int ORDER_W          = 5;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;
    localparam int LEVELS_PER_STAGE = 4;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic [0:0] REG_HILBERT_ORDER = 1'b0;

    typedef struct packed {
        logic        cmd;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [31:0] distance_in;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] distance_out;
        logic [15:0] x_out;
        logic [15:0] y_out;
    } rsp_item_t;

    typedef struct packed {
        logic decode;
        logic swp;
        logic inv;
    } hcic_ctl_t;

endpackage

FILE: hdl/hilbert_curve_index_codec_unit.sv
// Hilbert curve index codec top level: configuration port and the chain of level stages.
// Depends on hcic_pkg, hcic_cfg and hcic_stage.
//
// Converts (x, y) to Hilbert distance (cmd 0) or distance to (x, y) (cmd 1) on a
// 2^order by 2^order grid; order is set through the APB register at address 0
// (reset 16, values above MAX_ORDER act as MAX_ORDER). One item enters per cycle while
// cmd_stall is low, and its result is registered once in each pipeline stage,
// since each pipeline stage walks four curve levels, most significant first.
// A stall on the result side backs up stage by stage; bubbles are filled.
module hilbert_curve_index_codec_unit #(
    parameter int MAX_ORDER = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcic_pkg::ADDR_W-1:0]    paddr,
    input  logic [hcic_pkg::DATA_W-1:0]    pwdata,
    output logic [hcic_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  hcic_pkg::cmd_item_t            cmd_item,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output hcic_pkg::rsp_item_t            rsp_item
);

    localparam int LPS = hcic_pkg::LEVELS_PER_STAGE;
    localparam int NS  = (MAX_ORDER + LPS - 1) / LPS;
    localparam int W   = MAX_ORDER;
    localparam int DW  = 2 * MAX_ORDER;

    logic [hcic_pkg::ORDER_W-1:0] order_eff;

    logic                 vld   [0:NS];
    logic                 stl   [0:NS];
    hcic_pkg::hcic_ctl_t  ctl   [0:NS];
    logic [W-1:0]         xs    [0:NS];
    logic [W-1:0]         ys    [0:NS];
    logic [DW-1:0]        ds    [0:NS];
    logic                 is_dec;

    hcic_cfg #(
        .MAX_ORDER (MAX_ORDER)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .order_eff (order_eff)
    );

    assign is_dec     = (cmd_item.cmd == hcic_pkg::CMD_DECODE);
    assign vld[0]     = cmd_valid;
    assign cmd_stall  = stl[0];
    assign ctl[0].decode = is_dec;
    assign ctl[0].swp    = 1'b0;
    assign ctl[0].inv    = 1'b0;
    assign xs[0] = is_dec ? '0 : W'(cmd_item.x_coord);
    assign ys[0] = is_dec ? '0 : W'(cmd_item.y_coord);
    assign ds[0] = is_dec ? DW'(cmd_item.distance_in) : '0;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        hcic_stage #(
            .MAX_ORDER (MAX_ORDER),
            .STAGE_IDX (s)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .order_eff (order_eff),
            .up_valid  (vld[s]),
            .up_stall  (stl[s]),
            .up_ctl    (ctl[s]),
            .up_x      (xs[s]),
            .up_y      (ys[s]),
            .up_d      (ds[s]),
            .dn_valid  (vld[s+1]),
            .dn_stall  (stl[s+1]),
            .dn_ctl    (ctl[s+1]),
            .dn_x      (xs[s+1]),
            .dn_y      (ys[s+1]),
            .dn_d      (ds[s+1])
        );
    end

    assign rsp_valid  = vld[NS];
    assign stl[NS]    = rsp_stall;

    always_comb
    begin
        rsp_item = '0;
        if (ctl[NS].decode)
        begin
            rsp_item.x_out = 16'(xs[NS]);
            rsp_item.y_out = 16'(ys[NS]);
        end
        else
        begin
            rsp_item.distance_out = 32'(ds[NS]);
        end
    end

    ap_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.distance_out == '0) ||
                      (rsp_item.x_out == '0 && rsp_item.y_out == '0))
        else $error("result carries both a distance and coordinates");

    ap_order_sat: assert property (@(posedge clk) disable iff (!rst_n)
        order_eff <= hcic_pkg::ORDER_W'(MAX_ORDER))
        else $error("effective order above MAX_ORDER");

    ap_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_stall |-> !cmd_stall)
        else $error("input stalled while result side drains");

    ap_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> vld[1])
        else $error("input stalled with first stage empty");

    ap_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (vld[NS-1] && !rsp_stall) |=> rsp_valid)
        else $error("item lost in last stage");

endmodule

FILE: hdl/hcic_cfg.sv
// Configuration register file of the Hilbert curve index codec (APB-style port).
// Holds the curve order and gives it saturated to MAX_ORDER. Depends on hcic_pkg.
module hcic_cfg #(
    parameter int MAX_ORDER = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hcic_pkg::ADDR_W-1:0]         paddr,
    input  logic [hcic_pkg::DATA_W-1:0]         pwdata,
    output logic [hcic_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output logic [hcic_pkg::ORDER_W-1:0]        order_eff
);

    localparam logic [hcic_pkg::ORDER_W-1:0] MAX_ORD = hcic_pkg::ORDER_W'(MAX_ORDER);

    logic [hcic_pkg::ORDER_W-1:0] order_reg;
    logic [hcic_pkg::ORDER_W-1:0] order_next;
    logic                         sel_order;
    logic                         wr_en;

    assign sel_order = (paddr[hcic_pkg::ADDR_W-1:2] == hcic_pkg::REG_HILBERT_ORDER);
    assign wr_en     = psel && penable && pwrite && sel_order;
    assign pready    = 1'b1;

    always_comb
    begin
        order_next = order_reg;
        if (wr_en)
        begin
            order_next = pwdata[hcic_pkg::ORDER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= hcic_pkg::ORDER_RESET;
        end
        else
        begin
            order_reg <= order_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_order)
        begin
            prdata = hcic_pkg::DATA_W'(order_reg);
        end
    end

    assign order_eff = (order_reg > MAX_ORD) ? MAX_ORD : order_reg;

endmodule

FILE: hdl/hcic_stage.sv
// One pipeline stage of the Hilbert curve index codec: a group of curve levels and its register.
// Walks levels from the most significant one down, tracking swap and invert. Depends on hcic_pkg.
module hcic_stage #(
    parameter int MAX_ORDER = 16,
    parameter int STAGE_IDX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [hcic_pkg::ORDER_W-1:0]   order_eff,
    input  logic                           up_valid,
    output logic                           up_stall,
    input  hcic_pkg::hcic_ctl_t            up_ctl,
    input  logic [MAX_ORDER-1:0]           up_x,
    input  logic [MAX_ORDER-1:0]           up_y,
    input  logic [2*MAX_ORDER-1:0]         up_d,
    output logic                           dn_valid,
    input  logic                           dn_stall,
    output hcic_pkg::hcic_ctl_t            dn_ctl,
    output logic [MAX_ORDER-1:0]           dn_x,
    output logic [MAX_ORDER-1:0]           dn_y,
    output logic [2*MAX_ORDER-1:0]         dn_d
);

    localparam int LPS = hcic_pkg::LEVELS_PER_STAGE;
    localparam int W   = MAX_ORDER;
    localparam int DW  = 2 * MAX_ORDER;

    hcic_pkg::hcic_ctl_t  ctl_c [0:LPS];
    logic [W-1:0]         x_c   [0:LPS];
    logic [W-1:0]         y_c   [0:LPS];
    logic [DW-1:0]        d_c   [0:LPS];

    logic                 valid_reg;
    logic                 valid_next;
    hcic_pkg::hcic_ctl_t  ctl_reg;
    logic [W-1:0]         x_reg;
    logic [W-1:0]         y_reg;
    logic [DW-1:0]        d_reg;
    logic                 load;

    assign ctl_c[0] = up_ctl;
    assign x_c[0]   = up_x;
    assign y_c[0]   = up_y;
    assign d_c[0]   = up_d;

    for (genvar j = 0; j < LPS; j++)
    begin : g_level
        localparam int LV = MAX_ORDER - 1 - (STAGE_IDX * LPS + j);
        if (LV >= 0)
        begin : g_on
            logic en;
            logic ox;
            logic oy;
            logic bx;
            logic by;
            logic tx;
            logic ty;

            assign en = (hcic_pkg::ORDER_W'(LV) < order_eff);

            always_comb
            begin
                ctl_c[j+1] = ctl_c[j];
                x_c[j+1]   = x_c[j];
                y_c[j+1]   = y_c[j];
                d_c[j+1]   = d_c[j];
                if (ctl_c[j].decode)
                begin
                    bx = d_c[j][2*LV+1];
                    by = d_c[j][2*LV+1] ^ d_c[j][2*LV];
                    tx = bx ^ ctl_c[j].inv;
                    ty = by ^ ctl_c[j].inv;
                    ox = ctl_c[j].swp ? ty : tx;
                    oy = ctl_c[j].swp ? tx : ty;
                end
                else
                begin
                    ox = x_c[j][LV];
                    oy = y_c[j][LV];
                    tx = ctl_c[j].swp ? oy : ox;
                    ty = ctl_c[j].swp ? ox : oy;
                    bx = tx ^ ctl_c[j].inv;
                    by = ty ^ ctl_c[j].inv;
                end
                if (en)
                begin
                    ctl_c[j+1].swp = ctl_c[j].swp ^ !by;
                    ctl_c[j+1].inv = ctl_c[j].inv ^ (!by && bx);
                    if (ctl_c[j].decode)
                    begin
                        x_c[j+1][LV] = ox;
                        y_c[j+1][LV] = oy;
                    end
                    else
                    begin
                        d_c[j+1][2*LV+1] = bx;
                        d_c[j+1][2*LV]   = bx ^ by;
                    end
                end
            end
        end
        else
        begin : g_off
            assign ctl_c[j+1] = ctl_c[j];
            assign x_c[j+1]   = x_c[j];
            assign y_c[j+1]   = y_c[j];
            assign d_c[j+1]   = d_c[j];
        end
    end

    assign up_stall   = valid_reg && dn_stall;
    assign load       = up_valid && !up_stall;
    assign valid_next = up_stall ? valid_reg : up_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= ctl_c[LPS];
            x_reg   <= x_c[LPS];
            y_reg   <= y_c[LPS];
            d_reg   <= d_c[LPS];
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_d     = d_reg;

endmodule
